// ----- hdl/kmp_pkg.sv -----
// Shared types, constants and helpers for the KMP stream matcher.
// Used by kmp_core.sv and kmp_stream_matcher.sv; depends on nothing.
`default_nettype none

package kmp_pkg;

   localparam int MAX_PATTERN     = 32;
   localparam int IDX_BITS        = $clog2(MAX_PATTERN);
   localparam int LEN_BITS        = $clog2(MAX_PATTERN + 1);
   localparam int POSITION_BITS   = 32;
   localparam int MATCH_BITS      = 32;
   localparam int BYTE_BITS       = 8;
   localparam int CSR_DATA_BITS   = 64;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CFG_LEN_BITS    = 6;
   localparam int PATTERN_REGS    = 4;
   localparam int PATTERN_BITS    = PATTERN_REGS * CSR_DATA_BITS;
   localparam int PATTERN_BYTES   = PATTERN_BITS / BYTE_BITS;

   localparam logic MODE_RESTART = 1'b0;
   localparam logic MODE_TEXT    = 1'b1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PATTERN_LOW,
      CSR_PATTERN_SECOND,
      CSR_PATTERN_THIRD,
      CSR_PATTERN_HIGH,
      CSR_PATTERN_LENGTH
   } kmp_csr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUILD_SEED,
      ST_BUILD,
      ST_MATCH
   } kmp_state_type;

   typedef struct packed {
      logic                 mode;
      logic [BYTE_BITS-1:0] text_byte;
      logic                 last_byte;
   } kmp_req_type;

   typedef struct packed {
      logic                  found;
      logic [MATCH_BITS-1:0] match_start;
      logic                  finished;
   } kmp_result_type;

   // entry i holds pattern byte i and the failure link of byte i-1
   typedef struct packed {
      logic [BYTE_BITS-1:0] pat_byte;
      logic [IDX_BITS-1:0]  link;
   } kmp_entry_type;

   function automatic logic [BYTE_BITS-1:0] pattern_byte(
      input logic [PATTERN_BITS-1:0] pat,
      input logic [IDX_BITS-1:0]     idx
   );
      logic [BYTE_BITS-1:0] b;
      b = '0;
      if (int'(idx) < PATTERN_BYTES) begin
         b = pat[int'(idx) * BYTE_BITS +: BYTE_BITS];
      end
      return b;
   endfunction

   function automatic logic [LEN_BITS-1:0] clamp_length(
      input logic [CFG_LEN_BITS-1:0] cfg
   );
      logic [LEN_BITS-1:0] len;
      if (cfg == '0) begin
         len = LEN_BITS'(1);
      end else if (int'(cfg) > MAX_PATTERN) begin
         len = LEN_BITS'(MAX_PATTERN);
      end else begin
         len = LEN_BITS'(cfg);
      end
      return len;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/kmp_core.sv -----
// Failure-table builder and text matcher around one synchronous table memory.
// Depends on kmp_pkg.
`default_nettype none

module kmp_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire kmp_pkg::kmp_req_type                  req,
   input  wire logic [kmp_pkg::PATTERN_BITS-1:0]      pattern,
   input  wire logic [kmp_pkg::CFG_LEN_BITS-1:0]      pattern_length,
   output      logic                                  idle,
   output      logic                                  done,
   output      kmp_pkg::kmp_result_type               result
);

   kmp_pkg::kmp_state_type state_ff, state_in;

   logic [kmp_pkg::LEN_BITS-1:0]      len_ff, len_in;
   logic [kmp_pkg::IDX_BITS-1:0]      m_ff, m_in;
   logic [kmp_pkg::IDX_BITS-1:0]      cur_ff, cur_in;
   logic [kmp_pkg::IDX_BITS-1:0]      i_ff, i_in;
   logic [kmp_pkg::POSITION_BITS-1:0] pos_ff, pos_in;
   logic                              over_ff, over_in;
   logic                              valid_ff, valid_in;
   logic [kmp_pkg::BYTE_BITS-1:0]     char_ff, char_in;
   logic                              last_ff, last_in;

   kmp_pkg::kmp_entry_type mem [kmp_pkg::MAX_PATTERN];
   kmp_pkg::kmp_entry_type rd_data_ff;
   kmp_pkg::kmp_entry_type ent;
   kmp_pkg::kmp_entry_type wr_data;
   logic                          rd_en, wr_en;
   logic [kmp_pkg::IDX_BITS-1:0]  rd_addr, wr_addr;

   logic [kmp_pkg::BYTE_BITS-1:0]     cmp_byte;
   logic                              hit, follow, build_last;
   logic [kmp_pkg::IDX_BITS-1:0]      i_next, k_next;
   logic [kmp_pkg::LEN_BITS-1:0]      m_next;
   logic [kmp_pkg::POSITION_BITS-1:0] first_pos;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // table reads as all zero until the first restart
   assign ent      = valid_ff ? rd_data_ff : '0;
   assign cmp_byte = (state_ff == kmp_pkg::ST_BUILD) ?
                     kmp_pkg::pattern_byte(pattern, i_ff) : char_ff;
   assign hit      = (cmp_byte == ent.pat_byte);
   assign follow   = !hit && (cur_ff != '0);
   assign i_next   = i_ff + kmp_pkg::IDX_BITS'(1);
   assign k_next   = hit ? cur_ff + kmp_pkg::IDX_BITS'(1) : '0;
   assign m_next   = hit ? kmp_pkg::LEN_BITS'(cur_ff) + kmp_pkg::LEN_BITS'(1) : '0;
   assign build_last = (kmp_pkg::LEN_BITS'(i_next) == len_ff - kmp_pkg::LEN_BITS'(1));
   assign first_pos  = pos_ff - kmp_pkg::POSITION_BITS'(len_ff)
                       + kmp_pkg::POSITION_BITS'(1);
   assign idle       = (state_ff == kmp_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kmp_pkg::ST_IDLE: begin
            if (start && req.mode == kmp_pkg::MODE_RESTART) begin
               state_in = kmp_pkg::ST_BUILD_SEED;
            end else if (start && !over_ff) begin
               state_in = kmp_pkg::ST_MATCH;
            end
         end
         kmp_pkg::ST_BUILD_SEED: begin
            state_in = (len_ff <= kmp_pkg::LEN_BITS'(2)) ?
                       kmp_pkg::ST_IDLE : kmp_pkg::ST_BUILD;
         end
         kmp_pkg::ST_BUILD: begin
            if (!follow && build_last) begin
               state_in = kmp_pkg::ST_IDLE;
            end
         end
         kmp_pkg::ST_MATCH: begin
            if (!follow) begin
               state_in = kmp_pkg::ST_IDLE;
            end
         end
         default: state_in = kmp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      len_in   = len_ff;
      m_in     = m_ff;
      cur_in   = cur_ff;
      i_in     = i_ff;
      pos_in   = pos_ff;
      over_in  = over_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      rd_en    = 1'b0;
      rd_addr  = cur_ff;
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = '0;
      done     = 1'b0;
      result   = '0;
      unique case (state_ff)
         kmp_pkg::ST_IDLE: begin
            if (start && req.mode == kmp_pkg::MODE_RESTART) begin
               len_in   = kmp_pkg::clamp_length(pattern_length);
               wr_en    = 1'b1;
               wr_addr  = '0;
               wr_data.pat_byte = kmp_pkg::pattern_byte(pattern, '0);
               valid_in = 1'b1;
               m_in     = '0;
               pos_in   = '0;
               over_in  = 1'b0;
            end else if (start && over_ff) begin
               done            = 1'b1;
               result.finished = 1'b1;
            end else if (start) begin
               rd_en   = 1'b1;
               rd_addr = m_ff;
               cur_in  = m_ff;
               char_in = req.text_byte;
               last_in = req.last_byte;
            end
         end
         kmp_pkg::ST_BUILD_SEED: begin
            wr_en   = 1'b1;
            wr_addr = kmp_pkg::IDX_BITS'(1);
            wr_data.pat_byte = kmp_pkg::pattern_byte(pattern, kmp_pkg::IDX_BITS'(1));
            rd_en   = 1'b1;
            rd_addr = '0;
            cur_in  = '0;
            i_in    = kmp_pkg::IDX_BITS'(1);
            if (len_ff <= kmp_pkg::LEN_BITS'(2)) begin
               done = 1'b1;
            end
         end
         kmp_pkg::ST_BUILD: begin
            if (follow) begin
               cur_in  = ent.link;
               rd_en   = 1'b1;
               rd_addr = ent.link;
            end else begin
               wr_en   = 1'b1;
               wr_addr = i_next;
               wr_data.pat_byte = kmp_pkg::pattern_byte(pattern, i_next);
               wr_data.link     = k_next;
               if (build_last) begin
                  done = 1'b1;
               end else begin
                  i_in    = i_next;
                  cur_in  = k_next;
                  rd_en   = 1'b1;
                  rd_addr = k_next;
               end
            end
         end
         kmp_pkg::ST_MATCH: begin
            if (follow) begin
               cur_in  = ent.link;
               rd_en   = 1'b1;
               rd_addr = ent.link;
            end else begin
               done   = 1'b1;
               pos_in = pos_ff + kmp_pkg::POSITION_BITS'(1);
               if (m_next == len_ff) begin
                  result.found       = 1'b1;
                  result.match_start = kmp_pkg::MATCH_BITS'(first_pos);
                  result.finished    = 1'b1;
                  over_in            = 1'b1;
                  m_in               = '0;
               end else begin
                  m_in = m_next[kmp_pkg::IDX_BITS-1:0];
                  if (last_ff) begin
                     result.finished = 1'b1;
                     over_in         = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kmp_pkg::ST_IDLE;
         len_ff   <= kmp_pkg::LEN_BITS'(1);
         m_ff     <= '0;
         pos_ff   <= '0;
         over_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         m_ff     <= m_in;
         pos_ff   <= pos_in;
         over_ff  <= over_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      i_ff    <= i_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

endmodule

`default_nettype wire

// ----- hdl/kmp_stream_matcher.sv -----
// Top level of the KMP stream matcher: register file, handshakes, result register.
// Depends on kmp_pkg and kmp_core.
//
//   channel | direction | handshake          | payload
//   req_    | in        | req_valid/stall    | mode, text_byte, last_byte
//   rsp_    | out       | rsp_valid/stall    | found, match_start, finished
//   csr_    | in        | csr_write          | csr_index, csr_wdata
//
// Text byte: accepted in idle with a table read, then matched, with one more table read per
// failure link followed. Byte after the search has ended: answered from idle without a read.
// Restart: builds the failure table one pattern byte at a time, following links as needed.
// Reset clears the pattern registers and match state; the table reads zero until a restart.
// One item is in flight; a held result stalls the next transfer only while rsp_stall is high.
`default_nettype none

module kmp_stream_matcher (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_stall,
   input  wire logic                                 req_mode,
   input  wire logic [kmp_pkg::BYTE_BITS-1:0]        req_text_byte,
   input  wire logic                                 req_last_byte,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   output      logic                                 rsp_found,
   output      logic [kmp_pkg::MATCH_BITS-1:0]       rsp_match_start,
   output      logic                                 rsp_finished,
   input  wire logic                                 csr_write,
   input  wire logic [kmp_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [kmp_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   logic [kmp_pkg::CSR_DATA_BITS-1:0] pattern_ff [kmp_pkg::PATTERN_REGS];
   logic [kmp_pkg::CFG_LEN_BITS-1:0]  length_ff;
   logic                              rsp_valid_ff;
   kmp_pkg::kmp_result_type           rsp_ff;

   kmp_pkg::kmp_req_type    req;
   kmp_pkg::kmp_result_type result;
   logic                    start, core_idle, core_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < kmp_pkg::PATTERN_REGS; r++) begin
            pattern_ff[r] <= '0;
         end
         length_ff <= kmp_pkg::CFG_LEN_BITS'(1);
      end else if (csr_write) begin
         unique case (kmp_pkg::kmp_csr_type'(csr_index))
            kmp_pkg::CSR_PATTERN_LOW:    pattern_ff[0] <= csr_wdata;
            kmp_pkg::CSR_PATTERN_SECOND: pattern_ff[1] <= csr_wdata;
            kmp_pkg::CSR_PATTERN_THIRD:  pattern_ff[2] <= csr_wdata;
            kmp_pkg::CSR_PATTERN_HIGH:   pattern_ff[3] <= csr_wdata;
            kmp_pkg::CSR_PATTERN_LENGTH:
               length_ff <= csr_wdata[kmp_pkg::CFG_LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign req_stall     = !core_idle || (rsp_valid_ff && rsp_stall);
   assign start         = req_valid && !req_stall;
   assign req.mode      = req_mode;
   assign req.text_byte = req_text_byte;
   assign req.last_byte = req_last_byte;

   kmp_core u_core (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req            (req),
      .pattern        ({pattern_ff[3], pattern_ff[2], pattern_ff[1], pattern_ff[0]}),
      .pattern_length (length_ff),
      .idle           (core_idle),
      .done           (core_done),
      .result         (result)
   );

   // load on completion; the register is always free by then
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (core_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (core_done) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_ff.found;
   assign rsp_match_start = rsp_ff.match_start;
   assign rsp_finished    = rsp_ff.finished;

endmodule

`default_nettype wire

// ----- bench/kmp_stream_matcher_tb.sv -----
// Self-checking bench for kmp_stream_matcher: a queued request driver, a response
// monitor and an in-bench KMP search tracker that predicts every result.
// Depends on hdl/kmp_pkg.sv and the matcher RTL under hdl/.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 120;
   localparam int PHASE_ITEMS  = 100;
   localparam int PHASES       = 12;
   localparam int IDLE_PCT     = 25;

   logic                               clock           = 1'b0;
   logic                               reset           = 1'b1;
   logic                               req_valid       = 1'b0;
   logic                               req_mode        = kmp_pkg::MODE_TEXT;
   logic [kmp_pkg::BYTE_BITS-1:0]      req_text_byte   = '0;
   logic                               req_last_byte   = 1'b0;
   logic                               rsp_stall       = 1'b0;
   logic                               csr_write       = 1'b0;
   logic [kmp_pkg::CSR_INDEX_BITS-1:0] csr_index       = '0;
   logic [kmp_pkg::CSR_DATA_BITS-1:0]  csr_wdata       = '0;
   logic                               req_stall;
   logic                               rsp_valid;
   logic                               rsp_found;
   logic [kmp_pkg::MATCH_BITS-1:0]     rsp_match_start;
   logic                               rsp_finished;

   kmp_pkg::kmp_req_type    queued_reqs[$];
   kmp_pkg::kmp_result_type awaited_results[$];
   kmp_pkg::kmp_req_type    drive_req;
   kmp_pkg::kmp_result_type want;
   int             items_queued   = 0;
   int             items_accepted = 0;
   int             error_count    = 0;
   int             cycle_count    = 0;
   int             hold_asked     = 0;
   int             hold_served    = 0;
   int             hold_left      = 0;
   bit             quiet          = 1'b0;
   logic           req_sent       = 1'b0;

   // search tracker state
   logic [kmp_pkg::CSR_DATA_BITS-1:0] cfg_pattern [kmp_pkg::PATTERN_REGS];
   logic [kmp_pkg::CFG_LEN_BITS-1:0]  cfg_length;
   logic [kmp_pkg::BYTE_BITS-1:0]     pat_copy [kmp_pkg::MAX_PATTERN];
   int unsigned                       fail_link [kmp_pkg::MAX_PATTERN];
   int unsigned                       pat_len;
   int unsigned                       matched;
   logic [kmp_pkg::POSITION_BITS-1:0] position;
   bit                                over;

   // stimulus shaping for the current phase
   logic [kmp_pkg::BYTE_BITS-1:0]     phase_pat [kmp_pkg::PATTERN_BYTES];
   int                                eff_len;
   int                                alph_size;
   logic [kmp_pkg::BYTE_BITS-1:0]     alph_base;

   kmp_stream_matcher uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_text_byte   (req_text_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_match_start (rsp_match_start),
      .rsp_finished    (rsp_finished),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   task automatic search_step(input logic mode, input logic [kmp_pkg::BYTE_BITS-1:0] c,
                              input logic last);
      kmp_pkg::kmp_result_type           res;
      int unsigned                       k;
      int unsigned                       m;
      logic [kmp_pkg::POSITION_BITS-1:0] first_pos;
      res = '0;
      if (mode == kmp_pkg::MODE_RESTART) begin
         pat_len = int'(cfg_length);
         if (pat_len == 0) begin
            pat_len = 1;
         end else if (pat_len > kmp_pkg::MAX_PATTERN) begin
            pat_len = kmp_pkg::MAX_PATTERN;
         end
         for (int i = 0; i < kmp_pkg::MAX_PATTERN; i++) begin
            pat_copy[i] = (i < kmp_pkg::PATTERN_BYTES) ?
                          cfg_pattern[i / 8][(i % 8) * 8 +: 8] : '0;
            fail_link[i] = 0;
         end
         for (int i = 1; i < pat_len; i++) begin
            k = fail_link[i - 1];
            while (k > 0 && pat_copy[i] != pat_copy[k]) k = fail_link[k - 1];
            if (pat_copy[i] == pat_copy[k]) k++;
            fail_link[i] = k;
         end
         matched  = 0;
         position = '0;
         over     = 1'b0;
      end else if (over) begin
         res.finished = 1'b1;
      end else begin
         m = matched;
         while (m > 0 && c != pat_copy[m]) m = fail_link[m - 1];
         if (c == pat_copy[m]) m++;
         if (m >= pat_len) begin
            first_pos         = position - kmp_pkg::POSITION_BITS'(pat_len)
                                + kmp_pkg::POSITION_BITS'(1);
            res.found         = 1'b1;
            res.match_start   = kmp_pkg::MATCH_BITS'(first_pos);
            res.finished      = 1'b1;
            over              = 1'b1;
            matched           = 0;
         end else begin
            matched = m;
            if (last) begin
               res.finished = 1'b1;
               over         = 1'b1;
            end
         end
         position = position + kmp_pkg::POSITION_BITS'(1);
      end
      awaited_results.push_back(res);
   endtask

   task automatic flag_mismatch(input string what, input logic [63:0] exp_val,
                                input logic [63:0] got_val);
      $display("%0t: %s expected %0h got %0h", $time, what, exp_val, got_val);
      error_count++;
   endtask

   // monitor: check result transfers, predict on request transfers
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
      if (reset) begin
         req_sent <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               flag_mismatch("unexpected result, found/finished", '0,
                             64'({rsp_found, rsp_finished}));
            end else begin
               want = awaited_results.pop_front();
               if (rsp_found !== want.found)
                  flag_mismatch("found", 64'(want.found), 64'(rsp_found));
               if (rsp_match_start !== want.match_start)
                  flag_mismatch("match_start", 64'(want.match_start),
                                64'(rsp_match_start));
               if (rsp_finished !== want.finished)
                  flag_mismatch("finished", 64'(want.finished), 64'(rsp_finished));
            end
         end
         if (req_valid && !req_stall) begin
            search_step(req_mode, req_text_byte, req_last_byte);
            items_accepted++;
            req_sent <= 1'b1;
         end else begin
            req_sent <= 1'b0;
         end
      end
   end

   // driver: hold a stalled request, advance after a transfer
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_sent) begin
         if (queued_reqs.size() > 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
            drive_req = queued_reqs.pop_front();
            req_valid     <= 1'b1;
            req_mode      <= drive_req.mode;
            req_text_byte <= drive_req.text_byte;
            req_last_byte <= drive_req.last_byte;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result-side stall, with an occasional long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_asked) begin
         hold_served <= hold_asked;
         hold_left   <= HOLD_CYCLES;
         rsp_stall   <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
      end
   end

   function automatic logic [kmp_pkg::BYTE_BITS-1:0] pick_text();
      return alph_base + kmp_pkg::BYTE_BITS'($urandom_range(alph_size - 1));
   endfunction

   task automatic add_item(input logic mode, input logic [kmp_pkg::BYTE_BITS-1:0] b,
                           input logic last);
      kmp_pkg::kmp_req_type r;
      r.mode      = mode;
      r.text_byte = b;
      r.last_byte = last;
      queued_reqs.push_back(r);
      items_queued++;
   endtask

   task automatic add_search();
      logic [kmp_pkg::BYTE_BITS-1:0] text_q[$];
      int                            flaw;
      bit                            mark_last;
      add_item(kmp_pkg::MODE_RESTART, kmp_pkg::BYTE_BITS'($urandom_range(255)),
               1'($urandom_range(1)));
      repeat ($urandom_range(12)) text_q.push_back(pick_text());
      if ($urandom_range(99) < 65) begin
         flaw = ($urandom_range(99) < 30) ? int'($urandom_range(eff_len - 1)) : -1;
         for (int i = 0; i < eff_len; i++)
            text_q.push_back((i == flaw) ? pick_text() : phase_pat[i]);
      end
      repeat ($urandom_range(6)) text_q.push_back(pick_text());
      if (text_q.size() == 0) text_q.push_back(pick_text());
      mark_last = ($urandom_range(99) < 80);
      for (int i = 0; i < text_q.size(); i++)
         add_item(kmp_pkg::MODE_TEXT, text_q[i], mark_last && (i == text_q.size() - 1));
      repeat ($urandom_range(2))
         add_item(kmp_pkg::MODE_TEXT, pick_text(), 1'($urandom_range(1)));
   endtask

   task automatic add_noise();
      repeat ($urandom_range(6, 1))
         add_item(($urandom_range(99) < 15) ? kmp_pkg::MODE_RESTART : kmp_pkg::MODE_TEXT,
                  kmp_pkg::BYTE_BITS'($urandom_range(255)), $urandom_range(99) < 20);
   endtask

   task automatic csr_put(input kmp_pkg::kmp_csr_type idx,
                          input logic [kmp_pkg::CSR_DATA_BITS-1:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == kmp_pkg::CSR_PATTERN_LENGTH) begin
         cfg_length = val[kmp_pkg::CFG_LEN_BITS-1:0];
      end else begin
         cfg_pattern[idx] = val;
      end
   endtask

   task automatic set_phase(input int p);
      logic [kmp_pkg::CSR_DATA_BITS-1:0] regs [kmp_pkg::PATTERN_REGS];
      logic [kmp_pkg::CSR_DATA_BITS-1:0] len_word;
      logic [kmp_pkg::CFG_LEN_BITS-1:0]  len_cfg;
      alph_size = 2;
      alph_base = kmp_pkg::BYTE_BITS'($urandom_range(255));
      case (p)
         0: len_cfg = '0;
         1: begin
            len_cfg   = 6'd32;
            alph_size = 1;
            alph_base = 8'h00;
         end
         2: begin
            len_cfg   = 6'd63;
            alph_size = 1;
            alph_base = 8'hFF;
         end
         3: len_cfg = 6'd33;
         4: len_cfg = 6'd2;
         5: len_cfg = 6'd5;
         6: begin
            len_cfg   = 6'd8;
            alph_size = 3;
         end
         7: len_cfg = 6'd16;
         8: begin
            len_cfg   = 6'd3;
            alph_size = 256;
         end
         9: len_cfg = kmp_pkg::CFG_LEN_BITS'($urandom_range(12, 1));
         10: begin
            len_cfg   = kmp_pkg::CFG_LEN_BITS'($urandom_range(32, 1));
            alph_size = 3;
         end
         default: begin
            len_cfg   = 6'd1;
            alph_size = 256;
         end
      endcase
      if (len_cfg == 0) begin
         eff_len = 1;
      end else if (len_cfg > kmp_pkg::MAX_PATTERN) begin
         eff_len = kmp_pkg::MAX_PATTERN;
      end else begin
         eff_len = int'(len_cfg);
      end
      for (int i = 0; i < kmp_pkg::PATTERN_BYTES; i++) begin
         phase_pat[i] = (i < eff_len) ? pick_text() :
                        kmp_pkg::BYTE_BITS'($urandom_range(255));
         regs[i / 8][(i % 8) * 8 +: 8] = phase_pat[i];
      end
      len_word = {$urandom(), $urandom()};
      len_word[kmp_pkg::CFG_LEN_BITS-1:0] = len_cfg;
      csr_put(kmp_pkg::CSR_PATTERN_LOW, regs[0]);
      csr_put(kmp_pkg::CSR_PATTERN_SECOND, regs[1]);
      csr_put(kmp_pkg::CSR_PATTERN_THIRD, regs[2]);
      csr_put(kmp_pkg::CSR_PATTERN_HIGH, regs[3]);
      csr_put(kmp_pkg::CSR_PATTERN_LENGTH, len_word);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (items_accepted != items_queued || awaited_results.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   initial begin : stimulus
      int phase_start;
      foreach (cfg_pattern[i]) cfg_pattern[i] = '0;
      foreach (pat_copy[i]) begin
         pat_copy[i]  = '0;
         fail_link[i] = 0;
      end
      cfg_length = kmp_pkg::CFG_LEN_BITS'(1);
      pat_len    = 1;
      matched    = 0;
      position   = '0;
      over       = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset pattern is a single zero byte
      add_item(kmp_pkg::MODE_TEXT, 8'h00, 1'b0);
      add_item(kmp_pkg::MODE_TEXT, 8'hFF, 1'b1);
      add_item(kmp_pkg::MODE_RESTART, 8'hFF, 1'b1);
      add_item(kmp_pkg::MODE_TEXT, 8'hFF, 1'b0);
      add_item(kmp_pkg::MODE_TEXT, 8'hAA, 1'b0);
      add_item(kmp_pkg::MODE_TEXT, 8'h00, 1'b1);
      add_item(kmp_pkg::MODE_RESTART, 8'h00, 1'b0);
      add_item(kmp_pkg::MODE_TEXT, 8'h55, 1'b1);
      add_item(kmp_pkg::MODE_TEXT, 8'h00, 1'b0);
      add_item(kmp_pkg::MODE_RESTART, 8'h5A, 1'b0);
      add_item(kmp_pkg::MODE_TEXT, 8'h80, 1'b0);
      add_item(kmp_pkg::MODE_TEXT, 8'h01, 1'b0);
      add_item(kmp_pkg::MODE_TEXT, 8'h7F, 1'b1);

      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         set_phase(p);
         quiet = (p == 4);
         phase_start = items_queued;
         while (items_queued - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(99) < 85) begin
               add_search();
            end else begin
               add_noise();
            end
         end
         if (p == 5) hold_asked++;
      end
      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (awaited_results.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, awaited_results.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
